@@ hdl/pfd_pkg.sv @@
// ----------------------------------------------------------------------------
// PPM frame decoder package
// Register map, input kinds, configuration bundle and result control bits.
// ----------------------------------------------------------------------------
package pfd_pkg;

  typedef enum logic [1:0] {
    REG_MIN_PULSE    = 2'd0,
    REG_SYNC_GAP     = 2'd1,
    REG_MIN_CHANNELS = 2'd2,
    REG_TICK_SHIFT   = 2'd3
  } reg_idx_t;

  typedef enum logic {
    FUNC_EDGE = 1'b0,
    FUNC_READ = 1'b1
  } func_t;

  localparam logic [15:0] MIN_PULSE_RST    = 16'd500;
  localparam logic [15:0] SYNC_GAP_RST     = 16'd2500;
  localparam logic [4:0]  MIN_CHANNELS_RST = 5'd4;
  localparam logic [2:0]  TICK_SHIFT_RST   = 3'd0;

  typedef struct packed {
    logic [15:0] min_pulse;
    logic [15:0] sync_gap;
    logic [4:0]  min_channels;
    logic [2:0]  tick_shift;
  } cfg_t;

  typedef struct packed {
    logic frame_ready;
    logic read_valid;
  } res_ctl_t;

endpackage

@@ hdl/pfd_store.sv @@
// ----------------------------------------------------------------------------
// PPM frame decoder pulse store
// One write port and one registered read port over the channel slots.
// ----------------------------------------------------------------------------
module pfd_store #(
  parameter int DEPTH = 16,
  parameter int AW    = 4
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [15:0]   wr_data,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [15:0]   rd_data
);

  logic [15:0] mem [DEPTH];
  logic [15:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read data holds between reads so a stalled item keeps its value.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

@@ hdl/pfd_ctrl.sv @@
// ----------------------------------------------------------------------------
// PPM frame decoder edge control
// Classifies each edge interval, tracks the frame and drives the store ports.
// ----------------------------------------------------------------------------
module pfd_ctrl #(
  parameter int MAX_CHANNELS = 16,
  parameter int TIME_WIDTH   = 16,
  parameter int CNT_W        = 5,
  parameter int AW           = 4
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  pfd_pkg::cfg_t          cfg,
  input  logic                   accept,
  input  logic                   func,
  input  logic [TIME_WIDTH-1:0]  edge_time,
  input  logic [3:0]             read_channel,
  output logic                   wr_en,
  output logic [AW-1:0]          wr_addr,
  output logic [15:0]            wr_data,
  output logic [AW-1:0]          rd_addr,
  output pfd_pkg::res_ctl_t      res_ctl,
  output logic [CNT_W-1:0]       count_nxt
);

  localparam int CW = (TIME_WIDTH > 16) ? TIME_WIDTH : 16;
  localparam int KW = (CNT_W > 5) ? CNT_W : 5;

  logic [TIME_WIDTH-1:0] last_edge_time_r, last_edge_time_nxt;
  logic [CNT_W-1:0]      channel_index_r, channel_index_nxt;
  logic                  frame_bad_r, frame_bad_nxt;
  logic [CNT_W-1:0]      latched_count_r, latched_count_nxt;

  logic [TIME_WIDTH-1:0] interval;
  logic [CW-1:0]         interval_x;
  logic [CW-1:0]         shifted;
  logic                  is_short;
  logic                  is_sync;
  logic                  enough;
  logic                  full;

  assign interval   = edge_time - last_edge_time_r;
  assign interval_x = CW'(interval);
  assign shifted    = interval_x >> cfg.tick_shift;
  assign is_short   = interval_x < CW'(cfg.min_pulse);
  assign is_sync    = interval_x > CW'(cfg.sync_gap);
  assign enough     = KW'(channel_index_r) >= KW'(cfg.min_channels);
  assign full       = channel_index_r == CNT_W'(MAX_CHANNELS);

  assign wr_addr = AW'(channel_index_r);
  assign wr_data = shifted[15:0];
  assign rd_addr = AW'(read_channel);

  always_comb begin
    last_edge_time_nxt  = last_edge_time_r;
    channel_index_nxt   = channel_index_r;
    frame_bad_nxt       = frame_bad_r;
    latched_count_nxt   = latched_count_r;
    wr_en               = 1'b0;
    res_ctl.frame_ready = 1'b0;
    res_ctl.read_valid  = 1'b0;

    if (func == pfd_pkg::FUNC_EDGE) begin
      if (is_short) begin
        frame_bad_nxt = 1'b1;
      end else if (is_sync) begin
        if (enough) begin
          latched_count_nxt   = channel_index_r;
          res_ctl.frame_ready = 1'b1;
        end
        channel_index_nxt = '0;
        frame_bad_nxt     = 1'b0;
      end else if (!frame_bad_r) begin
        if (!full) begin
          wr_en             = accept;
          channel_index_nxt = channel_index_r + CNT_W'(1);
        end else begin
          frame_bad_nxt = 1'b1;
        end
      end
      last_edge_time_nxt = edge_time;
    end else begin
      // The latched count never exceeds the store depth, so this bounds the slot.
      res_ctl.read_valid = KW'(read_channel) < KW'(latched_count_r);
    end
  end

  assign count_nxt = latched_count_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_edge_time_r <= '0;
      channel_index_r  <= '0;
      frame_bad_r      <= 1'b1;
      latched_count_r  <= '0;
    end else if (accept) begin
      last_edge_time_r <= last_edge_time_nxt;
      channel_index_r  <= channel_index_nxt;
      frame_bad_r      <= frame_bad_nxt;
      latched_count_r  <= latched_count_nxt;
    end
  end

endmodule

@@ hdl/pfd_out.sv @@
// ----------------------------------------------------------------------------
// PPM frame decoder result pipeline
// Lines up control bits with the store read and holds the output register.
// ----------------------------------------------------------------------------
module pfd_out #(
  parameter int CNT_W = 5,
  parameter int OUT_W = 24
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              accept,
  input  pfd_pkg::res_ctl_t res_ctl,
  input  logic [CNT_W-1:0]  count,
  input  logic [15:0]       rd_data,
  input  logic              out_tready,
  output logic              in_tready,
  output logic              out_tvalid,
  output logic [OUT_W-1:0]  out_tdata
);

  logic              s1_valid_r, s1_valid_nxt;
  pfd_pkg::res_ctl_t s1_ctl_r;
  logic [CNT_W-1:0]  s1_count_r;
  logic              out_valid_r, out_valid_nxt;
  logic [OUT_W-1:0]  out_data_r, out_data_nxt;
  logic              advance;

  assign advance   = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || advance;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (accept) begin
      s1_valid_nxt = 1'b1;
    end else if (advance) begin
      s1_valid_nxt = 1'b0;
    end

    out_valid_nxt = out_valid_r;
    if (advance) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end

    out_data_nxt                        = '0;
    out_data_nxt[0]                     = s1_ctl_r.frame_ready;
    out_data_nxt[CNT_W:1]               = s1_count_r;
    out_data_nxt[CNT_W+16:CNT_W+1]      = s1_ctl_r.read_valid ? rd_data : 16'd0;
    out_data_nxt[CNT_W+17]              = s1_ctl_r.read_valid;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_ctl_r   <= res_ctl;
      s1_count_r <= count;
    end
    if (advance) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

@@ hdl/ppm_frame_decoder_top.sv @@
// ----------------------------------------------------------------------------
// PPM frame decoder top level
// A result passes the stage-one and output registers; out_tready can hold it.
// Throughput: one item per cycle unless out_tready stalls, set by the registered
// edge update and the one read port of the pulse store. Reset is synchronous,
// active low; it clears the frame state and the pipeline, not the pulse store.
// ----------------------------------------------------------------------------
module ppm_frame_decoder_top #(
  parameter int MAX_CHANNELS = 16,
  parameter int TIME_WIDTH   = 16,
  localparam int CNT_W = $clog2(MAX_CHANNELS + 1),
  localparam int IN_W  = ((TIME_WIDTH + 4 + 7) / 8) * 8,
  localparam int OUT_W = ((CNT_W + 18 + 7) / 8) * 8
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  input  logic [IN_W-1:0]     in_tdata,   // edge_time, read_channel
  input  logic                in_tuser,   // func
  output logic                out_tvalid,
  input  logic                out_tready,
  output logic [OUT_W-1:0]    out_tdata,  // frame_ready, channel_count, read_value, read_valid
  input  logic                cfg_psel,
  input  logic                cfg_penable,
  input  logic                cfg_pwrite,
  input  logic [3:0]          cfg_paddr,
  input  logic [31:0]         cfg_pwdata,
  output logic [31:0]         cfg_prdata,
  output logic                cfg_pready
);

  localparam int AW    = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;

  pfd_pkg::cfg_t     cfg_r;
  pfd_pkg::reg_idx_t reg_idx;
  logic              cfg_wr;
  logic              accept;
  logic              wr_en;
  logic [AW-1:0]     wr_addr;
  logic [15:0]       wr_data;
  logic [AW-1:0]     rd_addr;
  logic [15:0]       rd_data;
  pfd_pkg::res_ctl_t res_ctl;
  logic [CNT_W-1:0]  count_nxt;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign reg_idx    = pfd_pkg::reg_idx_t'(cfg_paddr[3:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.min_pulse    <= pfd_pkg::MIN_PULSE_RST;
      cfg_r.sync_gap     <= pfd_pkg::SYNC_GAP_RST;
      cfg_r.min_channels <= pfd_pkg::MIN_CHANNELS_RST;
      cfg_r.tick_shift   <= pfd_pkg::TICK_SHIFT_RST;
    end else if (cfg_wr) begin
      case (reg_idx)
        pfd_pkg::REG_MIN_PULSE:    cfg_r.min_pulse    <= cfg_pwdata[15:0];
        pfd_pkg::REG_SYNC_GAP:     cfg_r.sync_gap     <= cfg_pwdata[15:0];
        pfd_pkg::REG_MIN_CHANNELS: cfg_r.min_channels <= cfg_pwdata[4:0];
        pfd_pkg::REG_TICK_SHIFT:   cfg_r.tick_shift   <= cfg_pwdata[2:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      pfd_pkg::REG_MIN_PULSE:    cfg_prdata = 32'(cfg_r.min_pulse);
      pfd_pkg::REG_SYNC_GAP:     cfg_prdata = 32'(cfg_r.sync_gap);
      pfd_pkg::REG_MIN_CHANNELS: cfg_prdata = 32'(cfg_r.min_channels);
      pfd_pkg::REG_TICK_SHIFT:   cfg_prdata = 32'(cfg_r.tick_shift);
      default:                   cfg_prdata = 32'd0;
    endcase
  end

  assign accept = in_tvalid && in_tready;

  pfd_ctrl #(
    .MAX_CHANNELS (MAX_CHANNELS),
    .TIME_WIDTH   (TIME_WIDTH),
    .CNT_W        (CNT_W),
    .AW           (AW)
  ) u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg          (cfg_r),
    .accept       (accept),
    .func         (in_tuser),
    .edge_time    (in_tdata[TIME_WIDTH-1:0]),
    .read_channel (in_tdata[TIME_WIDTH+3:TIME_WIDTH]),
    .wr_en        (wr_en),
    .wr_addr      (wr_addr),
    .wr_data      (wr_data),
    .rd_addr      (rd_addr),
    .res_ctl      (res_ctl),
    .count_nxt    (count_nxt)
  );

  pfd_store #(
    .DEPTH (MAX_CHANNELS),
    .AW    (AW)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (accept),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  pfd_out #(
    .CNT_W (CNT_W),
    .OUT_W (OUT_W)
  ) u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .accept     (accept),
    .res_ctl    (res_ctl),
    .count      (count_nxt),
    .rd_data    (rd_data),
    .out_tready (out_tready),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tdata  (out_tdata)
  );

endmodule

@@ hdl/pfd_checker.sv @@
// ----------------------------------------------------------------------------
// PPM frame decoder port checker
// Watches the result channel for reset, hold and field consistency.
// ----------------------------------------------------------------------------
module pfd_checker #(
  parameter int CNT_W = 5,
  parameter int OUT_W = 24
) (
  input logic             clk,
  input logic             rst_n,
  input logic             out_tvalid,
  input logic             out_tready,
  input logic [OUT_W-1:0] out_tdata
);

  // A held result keeps its valid and its data.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  // No result is shown in the cycle after reset.
  a_reset: assert property (@(posedge clk)
    $past(!rst_n) |-> !out_tvalid)
    else $error("result valid right after reset");

  // An item is either an edge or a read, never both kinds of result.
  a_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !(out_tdata[0] && out_tdata[CNT_W+17]))
    else $error("frame_ready and read_valid both set");

  // A read that misses returns zero.
  a_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tdata[CNT_W+17] |-> out_tdata[CNT_W+16:CNT_W+1] == 16'd0)
    else $error("read_value nonzero without read_valid");

endmodule

bind ppm_frame_decoder_top pfd_checker #(
  .CNT_W (CNT_W),
  .OUT_W (OUT_W)
) u_pfd_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
